// ===== hw/rtl/crcfr_pkg.sv =====
// Shared types, register map and CRC byte-update functions for the frame receiver.
package crcfr_pkg;

  // Register map, indexed by paddr[3:2]
  localparam logic [1:0] REG_MAGIC    = 2'd0;
  localparam logic [1:0] REG_MIN_LEN  = 2'd1;
  localparam logic [1:0] REG_EXT_TYPE = 2'd2;

  localparam int unsigned ADDR_W = 4;
  localparam int unsigned DATA_W = 32;

  // Register reset values
  localparam logic [7:0] MAGIC_RST    = 8'h55;
  localparam logic [8:0] MIN_LEN_RST  = 9'd13;
  localparam logic [7:0] EXT_TYPE_RST = 8'h05;

  // Framing constants
  localparam logic [8:0]  MIN_LEN_FLOOR = 9'd3;
  localparam logic [7:0]  FIXED_EXT     = 8'h09;
  localparam logic [7:0]  CRC8_INIT     = 8'hEE;
  localparam logic [7:0]  CRC8_POLY     = 8'h31;
  localparam logic [15:0] CRC16_INIT    = 16'h496C;
  localparam logic [15:0] CRC16_POLY    = 16'h1021;

  // Default depth of the queue between front and back end
  localparam int unsigned QUEUE_DEPTH = 4;

  typedef struct packed {
    logic [7:0] magic;
    logic [8:0] min_len;
    logic [7:0] ext_type;
  } crcfr_cfg_t;

  // One queue entry: either a released header (three bytes) or one body byte
  typedef struct packed {
    logic            hdr;
    logic [2:0][7:0] bytes;
    logic [8:0]      len;
  } crcfr_entry_t;

  function automatic logic [7:0] rev8(input logic [7:0] v);
    logic [7:0] r;
    for (int k = 0; k < 8; k++) begin
      r[k] = v[7-k];
    end
    return r;
  endfunction

  function automatic logic [7:0] crc8_byte(input logic [7:0] c, input logic [7:0] b);
    logic [7:0] r;
    r = c ^ rev8(b);
    for (int k = 0; k < 8; k++) begin
      r = r[7] ? ({r[6:0], 1'b0} ^ CRC8_POLY) : {r[6:0], 1'b0};
    end
    return r;
  endfunction

  function automatic logic [15:0] crc16_byte(input logic [15:0] c, input logic [7:0] b);
    logic [15:0] r;
    r = c ^ {rev8(b), 8'h00};
    for (int k = 0; k < 8; k++) begin
      r = r[15] ? ({r[14:0], 1'b0} ^ CRC16_POLY) : {r[14:0], 1'b0};
    end
    return r;
  endfunction

endpackage

// ===== hw/rtl/crcfr_front.sv =====
// Front end: hunts for the frame header, checks it and classifies every byte.
module crcfr_front (
  input  logic                    clk,
  input  logic                    rst_n,
  input  crcfr_pkg::crcfr_cfg_t   cfg,
  input  logic                    accept,
  input  logic [7:0]              in_byte,
  output logic                    ent_push,
  output crcfr_pkg::crcfr_entry_t ent
);

  logic [1:0] held_cnt_r, held_cnt_nxt;
  logic [7:0] held0_r, held0_nxt;
  logic [7:0] held1_r, held1_nxt;
  logic       in_frame_r, in_frame_nxt;
  logic [8:0] seen_r, seen_nxt;
  logic [8:0] len_r, len_nxt;

  logic [8:0] decl;
  logic [8:0] min_len;
  logic       hdr_bad;
  logic       body_last;

  // Header evaluation on the type byte
  always_comb begin
    decl    = {(in_byte == cfg.ext_type) || (in_byte == crcfr_pkg::FIXED_EXT), held1_r};
    min_len = (cfg.min_len < crcfr_pkg::MIN_LEN_FLOOR) ? crcfr_pkg::MIN_LEN_FLOOR
                                                        : cfg.min_len;
    hdr_bad = (held0_r != cfg.magic) || (decl < min_len);
    body_last = ({1'b0, seen_r} + 10'd1) >= {1'b0, len_r};
  end

  // Classify the byte and advance the hunt
  always_comb begin
    held_cnt_nxt = held_cnt_r;
    held0_nxt    = held0_r;
    held1_nxt    = held1_r;
    in_frame_nxt = in_frame_r;
    seen_nxt     = seen_r;
    len_nxt      = len_r;
    ent_push     = 1'b0;
    ent.hdr      = 1'b0;
    ent.bytes    = {8'h00, 8'h00, in_byte};
    ent.len      = len_r;
    if (accept) begin
      if (in_frame_r) begin
        ent_push = 1'b1;
        seen_nxt = seen_r + 9'd1;
        if (body_last) begin
          in_frame_nxt = 1'b0;
        end
      end else begin
        case (held_cnt_r)
          2'd0: begin
            if (in_byte == cfg.magic) begin
              held0_nxt    = in_byte;
              held_cnt_nxt = 2'd1;
            end
          end
          2'd1: begin
            held1_nxt    = in_byte;
            held_cnt_nxt = 2'd2;
          end
          default: begin
            if (hdr_bad) begin
              // Rescan the held bytes for a new magic
              if (held1_r == cfg.magic) begin
                held0_nxt    = held1_r;
                held1_nxt    = in_byte;
                held_cnt_nxt = 2'd2;
              end else if (in_byte == cfg.magic) begin
                held0_nxt    = in_byte;
                held_cnt_nxt = 2'd1;
              end else begin
                held_cnt_nxt = 2'd0;
              end
            end else begin
              // Release the header
              ent_push     = 1'b1;
              ent.hdr      = 1'b1;
              ent.bytes    = {in_byte, held1_r, held0_r};
              ent.len      = decl;
              len_nxt      = decl;
              seen_nxt     = 9'd3;
              in_frame_nxt = (decl > 9'd3);
              held_cnt_nxt = 2'd0;
            end
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_cnt_r <= 2'd0;
      in_frame_r <= 1'b0;
      seen_r     <= 9'd0;
      len_r      <= 9'd0;
    end else begin
      held_cnt_r <= held_cnt_nxt;
      in_frame_r <= in_frame_nxt;
      seen_r     <= seen_nxt;
      len_r      <= len_nxt;
    end
  end

  always_ff @(posedge clk) begin
    held0_r <= held0_nxt;
    held1_r <= held1_nxt;
  end

endmodule

// ===== hw/rtl/crcfr_queue.sv =====
// Short queue of classified entries between front and back end.
module crcfr_queue #(
  parameter int unsigned DEPTH = crcfr_pkg::QUEUE_DEPTH
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    wr_en,
  input  crcfr_pkg::crcfr_entry_t wr_data,
  input  logic                    rd_en,
  output crcfr_pkg::crcfr_entry_t rd_data,
  output logic                    q_full,
  output logic                    q_empty
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  crcfr_pkg::crcfr_entry_t mem_r [DEPTH];
  logic [PTR_W-1:0] wptr_r, wptr_nxt;
  logic [PTR_W-1:0] rptr_r, rptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  assign q_full  = (cnt_r == CNT_W'(DEPTH));
  assign q_empty = (cnt_r == '0);
  assign rd_data = mem_r[rptr_r];

  // Advance pointers with wrap at the depth
  always_comb begin
    wptr_nxt = wptr_r;
    rptr_nxt = rptr_r;
    cnt_nxt  = cnt_r;
    if (wr_en) begin
      wptr_nxt = (wptr_r == PTR_W'(DEPTH - 1)) ? '0 : wptr_r + PTR_W'(1);
    end
    if (rd_en) begin
      rptr_nxt = (rptr_r == PTR_W'(DEPTH - 1)) ? '0 : rptr_r + PTR_W'(1);
    end
    case ({wr_en, rd_en})
      2'b10:   cnt_nxt = cnt_r + CNT_W'(1);
      2'b01:   cnt_nxt = cnt_r - CNT_W'(1);
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wptr_r] <= wr_data;
    end
  end

endmodule

// ===== hw/rtl/crcfr_back.sv =====
// Back end: expands entries into frame bytes, runs both CRCs and drives the result register.
module crcfr_back (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    q_empty,
  input  crcfr_pkg::crcfr_entry_t ent,
  output logic                    q_pop,
  input  logic                    pop,
  output logic                    empty,
  output logic [7:0]              out_byte,
  output logic                    out_first_of_frame,
  output logic                    out_last_of_frame,
  output logic                    out_crc_ok,
  output logic [8:0]              out_frame_length
);

  logic [1:0]  sub_r, sub_nxt;
  logic [8:0]  seen_r;
  logic [7:0]  hcrc_r;
  logic        hmatch_r;
  logic [15:0] fcrc_r;
  logic [7:0]  tlow_r;
  logic        out_vld_r;

  logic        advance;
  logic        start;
  logic [7:0]  b;
  logic [8:0]  i_cur;
  logic [7:0]  hcrc_in, hcrc_n;
  logic        hmatch_in, hmatch_n;
  logic [15:0] fcrc_in, fcrc_n;
  logic [7:0]  tlow_in, tlow_n;
  logic [9:0]  i_plus2;
  logic        last;
  logic        ok;

  assign advance = !q_empty && (!out_vld_r || pop);
  assign start   = ent.hdr && (sub_r == 2'd0);
  assign empty   = !out_vld_r;

  // Pick the byte of this cycle
  always_comb begin
    case (sub_r)
      2'd1:    b = ent.hdr ? ent.bytes[1] : ent.bytes[0];
      2'd2:    b = ent.hdr ? ent.bytes[2] : ent.bytes[0];
      default: b = ent.bytes[0];
    endcase
  end

  // Account one frame byte, restarting all checks on a header
  always_comb begin
    i_cur     = start ? 9'd0 : seen_r;
    hcrc_in   = start ? crcfr_pkg::CRC8_INIT : hcrc_r;
    hmatch_in = start ? 1'b0 : hmatch_r;
    fcrc_in   = start ? crcfr_pkg::CRC16_INIT : fcrc_r;
    tlow_in   = start ? 8'h00 : tlow_r;
    i_plus2   = {1'b0, i_cur} + 10'd2;

    hcrc_n   = (i_cur < 9'd3) ? crcfr_pkg::crc8_byte(hcrc_in, b) : hcrc_in;
    hmatch_n = (i_cur == 9'd3) ? (crcfr_pkg::rev8(hcrc_n) == b) : hmatch_in;
    fcrc_n   = (i_plus2 < {1'b0, ent.len}) ? crcfr_pkg::crc16_byte(fcrc_in, b) : fcrc_in;
    tlow_n   = (i_plus2 == {1'b0, ent.len}) ? b : tlow_in;
    last     = ({1'b0, i_cur} + 10'd1) >= {1'b0, ent.len};
    ok       = last && hmatch_n &&
               ({crcfr_pkg::rev8(fcrc_n[7:0]), crcfr_pkg::rev8(fcrc_n[15:8])} == {b, tlow_n});
  end

  // Step through the three header bytes, drop the entry when done
  always_comb begin
    sub_nxt = sub_r;
    q_pop   = 1'b0;
    if (advance) begin
      if (ent.hdr && (sub_r != 2'd2)) begin
        sub_nxt = sub_r + 2'd1;
      end else begin
        sub_nxt = 2'd0;
        q_pop   = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sub_r     <= 2'd0;
      out_vld_r <= 1'b0;
    end else begin
      sub_r <= sub_nxt;
      if (advance) begin
        out_vld_r <= 1'b1;
      end else if (pop) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  // Hold CRC state and the result payload
  always_ff @(posedge clk) begin
    if (advance) begin
      seen_r             <= i_cur + 9'd1;
      hcrc_r             <= hcrc_n;
      hmatch_r           <= hmatch_n;
      fcrc_r             <= fcrc_n;
      tlow_r             <= tlow_n;
      out_byte           <= b;
      out_first_of_frame <= start;
      out_last_of_frame  <= last;
      out_crc_ok         <= ok;
      out_frame_length   <= ent.len;
    end
  end

endmodule

// ===== hw/rtl/crc_checked_frame_receiver.sv =====
// Top level of the frame receiver: configuration registers, front end, queue and back end.
// Accepts one received byte per clock while full is low. Body bytes leave one per clock
// while results are popped. A header is released by its third byte and yields three results,
// which the back end likewise sends one per clock, so the entry queue (QUEUE_DEPTH entries)
// fills by two entries per header and full rises only if results are not popped. Every
// result passes through one output register. Registers: magic byte at 0x0, minimum frame
// length at 0x4, extended type at 0x8; write them only while no frame byte is in flight.
module crc_checked_frame_receiver #(
  parameter int unsigned QUEUE_DEPTH = crcfr_pkg::QUEUE_DEPTH
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         push,
  output logic                         full,
  input  logic [7:0]                   in_byte,
  output logic                         empty,
  input  logic                         pop,
  output logic [7:0]                   out_byte,
  output logic                         out_first_of_frame,
  output logic                         out_last_of_frame,
  output logic                         out_crc_ok,
  output logic [8:0]                   out_frame_length,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [crcfr_pkg::ADDR_W-1:0] paddr,
  input  logic [crcfr_pkg::DATA_W-1:0] pwdata,
  output logic [crcfr_pkg::DATA_W-1:0] prdata,
  output logic                         pready
);

  crcfr_pkg::crcfr_cfg_t   cfg_r;
  crcfr_pkg::crcfr_entry_t ent_in;
  crcfr_pkg::crcfr_entry_t ent_out;
  logic                    ent_push;
  logic                    q_pop;
  logic                    q_empty;
  logic                    q_full;
  logic                    cfg_wr;
  logic                    accept;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign full   = q_full;
  assign accept = push && !q_full;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.magic    <= crcfr_pkg::MAGIC_RST;
      cfg_r.min_len  <= crcfr_pkg::MIN_LEN_RST;
      cfg_r.ext_type <= crcfr_pkg::EXT_TYPE_RST;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        crcfr_pkg::REG_MAGIC:    cfg_r.magic    <= pwdata[7:0];
        crcfr_pkg::REG_MIN_LEN:  cfg_r.min_len  <= pwdata[8:0];
        crcfr_pkg::REG_EXT_TYPE: cfg_r.ext_type <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  // Read back configuration registers
  always_comb begin
    unique case (paddr[3:2])
      crcfr_pkg::REG_MAGIC:    prdata = {24'h0, cfg_r.magic};
      crcfr_pkg::REG_MIN_LEN:  prdata = {23'h0, cfg_r.min_len};
      crcfr_pkg::REG_EXT_TYPE: prdata = {24'h0, cfg_r.ext_type};
      default:                 prdata = '0;
    endcase
  end

  crcfr_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .accept   (accept),
    .in_byte  (in_byte),
    .ent_push (ent_push),
    .ent      (ent_in)
  );

  crcfr_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (ent_push),
    .wr_data (ent_in),
    .rd_en   (q_pop),
    .rd_data (ent_out),
    .q_full  (q_full),
    .q_empty (q_empty)
  );

  crcfr_back u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .q_empty            (q_empty),
    .ent                (ent_out),
    .q_pop              (q_pop),
    .pop                (pop),
    .empty              (empty),
    .out_byte           (out_byte),
    .out_first_of_frame (out_first_of_frame),
    .out_last_of_frame  (out_last_of_frame),
    .out_crc_ok         (out_crc_ok),
    .out_frame_length   (out_frame_length)
  );

endmodule

// ===== hw/rtl/crcfr_checker.sv =====
// Port-level checker for the frame receiver and its bind to the top level.
module crcfr_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       full,
  input logic       empty,
  input logic       pop,
  input logic [7:0] out_byte,
  input logic       out_first_of_frame,
  input logic       out_last_of_frame,
  input logic       out_crc_ok,
  input logic [8:0] out_frame_length
);

  // Reset leaves no result and room for input
  a_reset_clears: assert property (@(posedge clk) !rst_n |=> (empty && !full))
    else $error("result or full after reset");

  // A waiting result holds until it is taken
  a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !pop) |=> (!empty && $stable(out_byte) && $stable(out_last_of_frame)))
    else $error("waiting result changed");

  // crc_ok only on the last byte
  a_ok_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_crc_ok) |-> out_last_of_frame)
    else $error("crc_ok without last");

  // Declared length is never below three
  a_len_floor: assert property (@(posedge clk) disable iff (!rst_n)
    !empty |-> (out_frame_length >= 9'd3))
    else $error("frame length below three");

  // The opening byte of a frame is never its last byte
  a_first_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_first_of_frame) |-> !out_last_of_frame)
    else $error("first byte marked last");

endmodule

bind crc_checked_frame_receiver crcfr_checker u_crcfr_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .full               (full),
  .empty              (empty),
  .pop                (pop),
  .out_byte           (out_byte),
  .out_first_of_frame (out_first_of_frame),
  .out_last_of_frame  (out_last_of_frame),
  .out_crc_ok         (out_crc_ok),
  .out_frame_length   (out_frame_length)
);

// ===== sim/tb_top.sv =====
`timescale 1ns / 100ps
// Testbench for crc_checked_frame_receiver: byte-stream driver, frame predictor and result checker.
module tb_top;

  localparam logic [1:0] REG_SPARE = 2'd3;    // unmapped register slot
  localparam logic [8:0] EXT_LEN_ADD = 9'h100;
  localparam int SETTLE_CYCLES = 12;
  localparam int CYCLE_LIMIT = 600000;

  typedef struct packed {
    logic [7:0] data;
    logic       first;
    logic       last;
    logic       ok;
    logic [8:0] len;
  } frame_byte_t;

  // Bit-mirror helper; the CRCs below run in reflected (LSB-first) form
  function automatic logic [7:0] mirror8(input logic [7:0] v);
    logic [7:0] r;
    r = '0;
    for (int k = 0; k < 8; k++) r = {r[6:0], v[k]};
    return r;
  endfunction

  localparam logic [7:0]  CRC8_RPOLY   = mirror8(crcfr_pkg::CRC8_POLY);
  localparam logic [7:0]  CRC8_INIT_R  = mirror8(crcfr_pkg::CRC8_INIT);
  localparam logic [15:0] CRC16_RPOLY  = {mirror8(crcfr_pkg::CRC16_POLY[7:0]),
                                          mirror8(crcfr_pkg::CRC16_POLY[15:8])};
  localparam logic [15:0] CRC16_INIT_R = {mirror8(crcfr_pkg::CRC16_INIT[7:0]),
                                          mirror8(crcfr_pkg::CRC16_INIT[15:8])};

  function automatic logic [7:0] crc8_step(input logic [7:0] c, input logic [7:0] b);
    logic [7:0] r;
    r = c ^ b;
    for (int k = 0; k < 8; k++) r = r[0] ? ((r >> 1) ^ CRC8_RPOLY) : (r >> 1);
    return r;
  endfunction

  function automatic logic [15:0] crc16_step(input logic [15:0] c, input logic [7:0] b);
    logic [15:0] r;
    r = c ^ {8'h00, b};
    for (int k = 0; k < 8; k++) r = r[0] ? ((r >> 1) ^ CRC16_RPOLY) : (r >> 1);
    return r;
  endfunction

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic push = 1'b0;
  logic [7:0] in_byte = 8'h00;
  logic pop = 1'b0;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [crcfr_pkg::ADDR_W-1:0] paddr = '0;
  logic [crcfr_pkg::DATA_W-1:0] pwdata = '0;
  logic full, empty, pready;
  logic [7:0] out_byte;
  logic out_first_of_frame, out_last_of_frame, out_crc_ok;
  logic [8:0] out_frame_length;
  logic [crcfr_pkg::DATA_W-1:0] prdata;

  crc_checked_frame_receiver uut (
    .clk(clk), .rst_n(rst_n),
    .push(push), .full(full), .in_byte(in_byte),
    .empty(empty), .pop(pop),
    .out_byte(out_byte), .out_first_of_frame(out_first_of_frame),
    .out_last_of_frame(out_last_of_frame), .out_crc_ok(out_crc_ok),
    .out_frame_length(out_frame_length),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #1 clk = ~clk;

  // Receiver configuration as last written
  logic [7:0] cfg_magic;
  logic [8:0] cfg_min;
  logic [7:0] cfg_ext;

  // Receiver state: hunt buffer and running frame
  logic [7:0]  rx_hold [0:2];
  int          rx_hold_cnt;
  bit          rx_in_frame;
  logic [8:0]  rx_pos;
  logic [8:0]  rx_len;
  logic [7:0]  rx_hcrc;
  bit          rx_hok;
  logic [15:0] rx_fcrc;
  logic [7:0]  rx_trail_lo;

  frame_byte_t bytes_due[$];
  logic [7:0]  link_bytes[$];
  int          bytes_queued = 0;
  int          fails = 0;
  int          cycle_count = 0;
  int          send_hold = 0;
  int          recv_hold = 0;
  bit          idle_on = 1'b0;
  frame_byte_t want;

  function automatic logic [8:0] min_len_eff();
    return (cfg_min < crcfr_pkg::MIN_LEN_FLOOR) ? crcfr_pkg::MIN_LEN_FLOOR : cfg_min;
  endfunction

  // Account one frame byte; return 1 on the closing byte
  function automatic bit frame_take(input logic [7:0] b, output bit ok);
    bit last;
    if (rx_pos < 3) rx_hcrc = crc8_step(rx_hcrc, b);
    if (rx_pos == 3) rx_hok = (rx_hcrc == b);
    if (int'(rx_pos) + 2 < int'(rx_len)) rx_fcrc = crc16_step(rx_fcrc, b);
    else if (int'(rx_pos) + 2 == int'(rx_len)) rx_trail_lo = b;
    last = (int'(rx_pos) + 1 >= int'(rx_len));
    ok = last && rx_hok && (rx_fcrc == {b, rx_trail_lo});
    rx_pos = rx_pos + 9'd1;
    return last;
  endfunction

  function automatic void release_byte(input logic [7:0] b, input bit first, input bit last,
                                       input bit ok);
    frame_byte_t r;
    r.data = b;
    r.first = first;
    r.last = last;
    r.ok = ok;
    r.len = rx_len;
    bytes_due.push_back(r);
  endfunction

  // Advance the receiver by one accepted byte
  function automatic void rx_accept(input logic [7:0] b);
    logic [8:0] dl;
    bit last, ok;
    if (rx_in_frame) begin
      last = frame_take(b, ok);
      release_byte(b, 1'b0, last, ok);
      if (last) rx_in_frame = 1'b0;
    end else if (rx_hold_cnt == 0) begin
      if (b == cfg_magic) begin
        rx_hold[0] = b;
        rx_hold_cnt = 1;
      end
    end else if (rx_hold_cnt == 1) begin
      rx_hold[1] = b;
      rx_hold_cnt = 2;
    end else begin
      rx_hold[2] = b;
      dl = {1'b0, rx_hold[1]};
      if (rx_hold[2] == cfg_ext || rx_hold[2] == crcfr_pkg::FIXED_EXT) dl = dl + EXT_LEN_ADD;
      if (rx_hold[0] != cfg_magic || dl < min_len_eff()) begin
        // drop the header and rescan the two later bytes
        if (rx_hold[1] == cfg_magic) begin
          rx_hold[0] = rx_hold[1];
          rx_hold[1] = rx_hold[2];
          rx_hold_cnt = 2;
        end else if (rx_hold[2] == cfg_magic) begin
          rx_hold[0] = rx_hold[2];
          rx_hold_cnt = 1;
        end else begin
          rx_hold_cnt = 0;
        end
      end else begin
        rx_len = dl;
        rx_pos = '0;
        rx_hcrc = CRC8_INIT_R;
        rx_hok = 1'b0;
        rx_fcrc = CRC16_INIT_R;
        rx_trail_lo = '0;
        rx_hold_cnt = 0;
        last = 1'b0;
        for (int j = 0; j < 3 && !last; j++) begin
          last = frame_take(rx_hold[j], ok);
          release_byte(rx_hold[j], j == 0, last, ok);
        end
        rx_in_frame = !last;
      end
    end
  endfunction

  function automatic void queue_byte(input logic [7:0] b);
    link_bytes.push_back(b);
    bytes_queued++;
  endfunction

  // Type byte that does not extend the length
  function automatic logic [7:0] plain_type();
    logic [7:0] t;
    do t = 8'($urandom); while (t == cfg_ext || t == crcfr_pkg::FIXED_EXT);
    return t;
  endfunction

  // Queue a well-formed frame of n bytes, optionally with one bit flipped past the header
  function automatic void send_frame(input int n, input bit damage);
    logic [7:0] fr[];
    logic [7:0] h;
    logic [15:0] f;
    int k;
    fr = new[n];
    for (k = 0; k < n; k++) fr[k] = 8'($urandom);
    fr[0] = cfg_magic;
    fr[1] = n[7:0];
    fr[2] = (n > 255) ? ($urandom_range(0, 1) ? cfg_ext : crcfr_pkg::FIXED_EXT)
                      : plain_type();
    h = CRC8_INIT_R;
    for (k = 0; k < 3; k++) h = crc8_step(h, fr[k]);
    if (n > 3) fr[3] = h;
    if (n > 4) begin
      f = CRC16_INIT_R;
      for (k = 0; k < n - 2; k++) f = crc16_step(f, fr[k]);
      fr[n-2] = f[7:0];
      fr[n-1] = f[15:8];
    end
    if (damage && n > 3) begin
      k = $urandom_range(3, n - 1);
      fr[k] = fr[k] ^ 8'(1 << $urandom_range(0, 7));
    end
    for (k = 0; k < n; k++) queue_byte(fr[k]);
  endfunction

  // Mostly valid frames, some damaged, short headers and line noise
  function automatic void random_traffic(input int budget);
    int start, pick, n, hi;
    start = bytes_queued;
    while (bytes_queued - start < budget) begin
      pick = $urandom_range(0, 99);
      n = int'(min_len_eff()) + int'($urandom_range(0, 12));
      if (n > 511) n = 511;
      if (pick < 75) begin
        send_frame(n, 1'b0);
      end else if (pick < 87) begin
        send_frame(n, 1'b1);
      end else if (pick < 93 && min_len_eff() > crcfr_pkg::MIN_LEN_FLOOR) begin
        hi = (min_len_eff() > 256) ? 255 : int'(min_len_eff()) - 1;
        queue_byte(cfg_magic);
        queue_byte(8'($urandom_range(0, hi)));
        queue_byte(plain_type());
      end else begin
        repeat ($urandom_range(1, 5))
          queue_byte(($urandom_range(0, 3) == 0) ? cfg_magic : 8'($urandom));
      end
    end
  endfunction

  task automatic reg_write(input logic [1:0] idx, input logic [crcfr_pkg::DATA_W-1:0] val);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      crcfr_pkg::REG_MAGIC:    cfg_magic = val[7:0];
      crcfr_pkg::REG_MIN_LEN:  cfg_min = val[8:0];
      crcfr_pkg::REG_EXT_TYPE: cfg_ext = val[7:0];
      default: ;
    endcase
  endtask

  // Wait for all bytes and results, close any open frame with filler, then settle
  task automatic settle();
    forever begin
      do @(negedge clk);
      while (link_bytes.size() != 0 || push || bytes_due.size() != 0);
      if (!rx_in_frame) break;
      repeat (int'(rx_len) - int'(rx_pos)) queue_byte(8'h00);
    end
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Byte driver: present the next pending byte, with random gaps
  always @(posedge clk) begin
    if (!rst_n) begin
      push <= 1'b0;
    end else begin
      if (push && !full) rx_accept(in_byte);
      if (!push || !full) begin
        if (send_hold == 0 && idle_on && link_bytes.size() != 0 && $urandom_range(0, 9) == 0)
          send_hold = $urandom_range(1, 18);
        if (send_hold != 0) begin
          send_hold--;
          push <= 1'b0;
        end else if (link_bytes.size() != 0) begin
          push <= 1'b1;
          in_byte <= link_bytes.pop_front();
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  // Result monitor: check each transfer against the oldest expected byte, stall at random
  always @(posedge clk) begin
    if (!rst_n) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (bytes_due.size() == 0) begin
          $error("out_byte: expected none, got %02h", out_byte);
          fails++;
        end else begin
          want = bytes_due.pop_front();
          if (out_byte !== want.data) begin
            $error("out_byte: expected %02h, got %02h", want.data, out_byte);
            fails++;
          end
          if (out_first_of_frame !== want.first) begin
            $error("first_of_frame: expected %0b, got %0b", want.first, out_first_of_frame);
            fails++;
          end
          if (out_last_of_frame !== want.last) begin
            $error("last_of_frame: expected %0b, got %0b", want.last, out_last_of_frame);
            fails++;
          end
          if (out_crc_ok !== want.ok) begin
            $error("crc_ok: expected %0b, got %0b", want.ok, out_crc_ok);
            fails++;
          end
          if (out_frame_length !== want.len) begin
            $error("frame_length: expected %0d, got %0d", want.len, out_frame_length);
            fails++;
          end
        end
      end
      if (recv_hold == 0 && idle_on && $urandom_range(0, 11) == 0)
        recv_hold = $urandom_range(1, 18);
      if (recv_hold != 0) begin
        recv_hold--;
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb_top: FAIL");
      $finish;
    end
  end

  initial begin
    cfg_magic = crcfr_pkg::MAGIC_RST;
    cfg_min = crcfr_pkg::MIN_LEN_RST;
    cfg_ext = crcfr_pkg::EXT_TYPE_RST;
    rx_hold[0] = '0;
    rx_hold[1] = '0;
    rx_hold[2] = '0;
    rx_hold_cnt = 0;
    rx_in_frame = 1'b0;
    rx_pos = '0;
    rx_len = '0;
    rx_hcrc = CRC8_INIT_R;
    rx_hok = 1'b0;
    rx_fcrc = CRC16_INIT_R;
    rx_trail_lo = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    idle_on = 1'b1;

    // Reset settings: short header rescanned onto a trailing magic, then a good frame;
    // leave a magic held in the hunt buffer
    queue_byte(cfg_magic);
    queue_byte(8'h02);
    send_frame(13, 1'b0);
    queue_byte(cfg_magic);
    settle();

    // Change magic while one is held, floor the minimum, touch the unmapped slot
    reg_write(crcfr_pkg::REG_MAGIC, 32'hA7);
    reg_write(crcfr_pkg::REG_MIN_LEN, 32'h0);
    reg_write(crcfr_pkg::REG_EXT_TYPE, 32'hFF);
    reg_write(REG_SPARE, 32'hFFFF_FFFF);
    queue_byte(cfg_magic);
    queue_byte(8'h02);
    queue_byte(8'h03);
    send_frame(3, 1'b0);
    send_frame(4, 1'b0);
    send_frame(6, 1'b0);
    settle();

    // Low extremes
    reg_write(crcfr_pkg::REG_MAGIC, 32'h00);
    reg_write(crcfr_pkg::REG_MIN_LEN, 32'd3);
    reg_write(crcfr_pkg::REG_EXT_TYPE, 32'h00);
    random_traffic(60);
    settle();

    // High extremes: headers just short of the maximum length, plain and extended, are dropped
    reg_write(crcfr_pkg::REG_MAGIC, 32'hFF);
    reg_write(crcfr_pkg::REG_MIN_LEN, 32'd511);
    reg_write(crcfr_pkg::REG_EXT_TYPE, 32'hFF);
    queue_byte(cfg_magic);
    queue_byte(8'hFF);
    queue_byte(8'h00);
    queue_byte(cfg_magic);
    queue_byte(8'hFE);
    queue_byte(cfg_ext);
    queue_byte(cfg_magic);
    queue_byte(8'hFE);
    queue_byte(crcfr_pkg::FIXED_EXT);
    settle();

    // Random settings
    reg_write(crcfr_pkg::REG_MAGIC, 32'($urandom_range(0, 255)));
    reg_write(crcfr_pkg::REG_MIN_LEN, 32'($urandom_range(3, 24)));
    reg_write(crcfr_pkg::REG_EXT_TYPE, 32'($urandom_range(0, 255)));
    random_traffic(50);
    settle();

    // Back to reset values, full rate on both sides
    idle_on = 1'b0;
    reg_write(crcfr_pkg::REG_MAGIC, 32'(crcfr_pkg::MAGIC_RST));
    reg_write(crcfr_pkg::REG_MIN_LEN, 32'(crcfr_pkg::MIN_LEN_RST));
    reg_write(crcfr_pkg::REG_EXT_TYPE, 32'(crcfr_pkg::EXT_TYPE_RST));
    random_traffic(70);
    settle();

    if (fails == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule

// ===== crc_checked_frame_receiver.f =====
hw/rtl/crcfr_pkg.sv
hw/rtl/crcfr_front.sv
hw/rtl/crcfr_queue.sv
hw/rtl/crcfr_back.sv
hw/rtl/crc_checked_frame_receiver.sv
hw/rtl/crcfr_checker.sv
sim/tb_top.sv
